### sv/bfi_pkg.sv
// ----------------------------------------------------------------------------
// bfi_pkg
// Shared types, sizes and codes of the binned field interpolator.
// ----------------------------------------------------------------------------
package bfi_pkg;

	localparam int LAYERS  = 128;
	localparam int BINS    = 128;
	localparam int TABLES  = 2 * LAYERS;
	localparam int TIX_W   = $clog2(TABLES);
	localparam int SAMPLES = TABLES * BINS;
	localparam int SADDR_W = $clog2(SAMPLES);
	localparam int BIN_W   = $clog2(BINS);

	localparam int FIELD_W = 24;
	localparam int COORD_W = 24;
	localparam int GEO_W   = 23;
	localparam int LAYER_W = 7;
	localparam int IDX_W   = 7;

	localparam int QUEUE_DEPTH = 4;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_UNIFORM_MODE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNIFORM_FIELD = 1'd1;
	localparam logic signed [FIELD_W-1:0] UNIFORM_FIELD_RST = 24'sd262144;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_GEO    = 2'd1,
		CMD_LOOKUP = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE,
		KIND_GEO,
		KIND_LOOKUP,
		KIND_CONST
	} kind_t;

	typedef struct packed {
		cmd_t                        command;
		logic [LAYER_W-1:0]          layer;
		logic                        table_select;
		logic [IDX_W-1:0]            bin_index;
		logic signed [FIELD_W-1:0]   sample_value;
		logic signed [COORD_W-1:0]   coordinate;
		logic [GEO_W-1:0]            table_origin;
		logic [GEO_W-1:0]            bin_width;
	} bfi_in_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] field_value;
		logic                      out_of_range;
	} bfi_out_t;

	typedef struct packed {
		logic                      uniform_mode;
		logic signed [FIELD_W-1:0] uniform_field;
	} bfi_cfg_t;

	// classified transaction as queued between front and back
	typedef struct packed {
		kind_t              kind;
		logic [TIX_W-1:0]   tix;
		logic [IDX_W-1:0]   wbin;
		logic [FIELD_W-1:0] val;
		logic               oor;
		logic [GEO_W-1:0]   org;
		logic [GEO_W-1:0]   wid;
	} bfi_op_t;

endpackage

### sv/bfi_ram.sv
// ----------------------------------------------------------------------------
// bfi_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module bfi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### sv/bfi_front.sv
// ----------------------------------------------------------------------------
// bfi_front
// Classifies an incoming transaction into a table write, a lookup or a
// fixed result, and drops what has no effect.
// ----------------------------------------------------------------------------
module bfi_front (
	input  bfi_pkg::bfi_in_t  req,
	input  bfi_pkg::bfi_cfg_t cfg,
	output logic              keep,
	output bfi_pkg::bfi_op_t  op
);
	import bfi_pkg::*;

	logic               layer_ok;
	logic               bin_ok;
	logic [COORD_W-1:0] mag;

	always_comb begin
		layer_ok = 32'(req.layer) < LAYERS;
		bin_ok   = 32'(req.bin_index) < BINS;
		mag      = req.coordinate[COORD_W-1] ? (~req.coordinate + COORD_W'(1)) : req.coordinate;

		op.kind = KIND_CONST;
		op.tix  = TIX_W'({req.layer, req.table_select});
		op.wbin = req.bin_index;
		op.val  = '0;
		op.oor  = 1'b0;
		op.org  = req.table_origin;
		op.wid  = req.bin_width;
		keep    = 1'b0;

		unique case (req.command)
			CMD_SAMPLE: begin
				op.kind = KIND_SAMPLE;
				op.val  = req.sample_value;
				keep    = layer_ok && bin_ok;
			end
			CMD_GEO: begin
				op.kind = KIND_GEO;
				keep    = layer_ok;
			end
			CMD_LOOKUP: begin
				keep = 1'b1;
				if (cfg.uniform_mode) begin
					op.val = cfg.uniform_field;
				end else if (!layer_ok) begin
					op.oor = 1'b1;
				end else begin
					op.kind = KIND_LOOKUP;
					op.val  = mag;
				end
			end
			default: keep = 1'b0;
		endcase
	end

endmodule

### sv/bfi_queue.sv
// ----------------------------------------------------------------------------
// bfi_queue
// Short register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module bfi_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bfi_pkg::bfi_op_t din,
	input  logic             pop,
	output bfi_pkg::bfi_op_t dout,
	output logic             full,
	output logic             empty
);
	import bfi_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	bfi_op_t          store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == QUEUE_DEPTH - 1) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == QUEUE_DEPTH - 1) ? '0 : rd_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	assign dout  = store_q[rd_q];
	assign full  = 32'(cnt_q) == QUEUE_DEPTH;
	assign empty = cnt_q == '0;

endmodule

### sv/bfi_back.sv
// ----------------------------------------------------------------------------
// bfi_back
// Executes queued transactions: table writes, bin search by pipelined
// division, sample fetch, interpolation and the rounding division.
// ----------------------------------------------------------------------------
module bfi_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bfi_pkg::bfi_op_t  op,
	input  logic              head_valid,
	output logic              pop,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output bfi_pkg::bfi_out_t rsp
);
	import bfi_pkg::*;

	localparam int NUM_W  = COORD_W + 3;
	localparam int TW_W   = GEO_W + 1;
	localparam int D1_W   = NUM_W + BIN_W;
	localparam int MB_W   = TW_W + BIN_W;
	localparam int DIFF_W = FIELD_W + 1;
	localparam int PROD_W = DIFF_W + NUM_W;
	localparam int A_W    = PROD_W + 1;
	localparam int Q_W    = FIELD_W + 2;
	localparam int RES_W  = Q_W + 2;
	localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(2 ** (FIELD_W - 1) - 1);
	localparam logic signed [RES_W-1:0] RES_MIN = -RES_MAX - RES_W'(1);

	typedef struct packed {
		logic               valid;
		kind_t              kind;
		logic [TIX_W-1:0]   tix;
		logic [IDX_W-1:0]   wbin;
		logic [FIELD_W-1:0] val;
		logic               oor;
	} tag_t;

	typedef struct packed {
		tag_t                    tag;
		logic signed [NUM_W-1:0] num;
		logic [GEO_W-1:0]        w;
		logic [TW_W-1:0]         tw;
		logic                    neg;
		logic                    sat;
		logic                    oor_hi;
		logic [D1_W-1:0]         rem;
		logic [BIN_W-1:0]        q;
	} div1_t;

	typedef struct packed {
		tag_t                      tag;
		logic signed [FIELD_W-1:0] f1;
		logic [TW_W-1:0]           tw;
		logic                      neg;
		logic                      sat;
		logic [A_W-1:0]            rem;
		logic [Q_W-1:0]            q;
	} div2_t;

	logic adv;
	logic rsp_valid_q;

	assign adv       = !rsp_valid_q || rsp_ready;
	assign pop       = adv && head_valid;
	assign rsp_valid = rsp_valid_q;

	// geometry fetch
	logic [2*GEO_W-1:0] geo_rd;
	tag_t               tag_s1;

	bfi_ram #(.WIDTH(2 * GEO_W), .DEPTH(TABLES)) u_geo_ram (
		.clk   (clk),
		.we    (pop && op.kind == KIND_GEO),
		.waddr (op.tix),
		.wdata ({op.org, op.wid}),
		.re    (adv),
		.raddr (op.tix),
		.rdata (geo_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1 <= '{valid: head_valid, kind: op.kind, tix: op.tix, wbin: op.wbin,
				val: op.val, oor: op.oor};
		end
	end

	// numerator 2*(x - origin) - width
	logic [GEO_W-1:0]        org_c;
	logic [GEO_W-1:0]        w_c;
	logic signed [NUM_W-1:0] num_c;
	tag_t                    tag_s2;
	logic signed [NUM_W-1:0] num_s2;
	logic [GEO_W-1:0]        w_s2;
	logic [TW_W-1:0]         tw_s2;

	always_comb begin
		org_c = geo_rd[2*GEO_W-1:GEO_W];
		w_c   = (geo_rd[GEO_W-1:0] == '0) ? GEO_W'(1) : geo_rd[GEO_W-1:0];
		num_c = $signed({2'b00, tag_s1.val, 1'b0}) - $signed({3'b000, org_c, 1'b0})
			- $signed({4'b0000, w_c});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2 <= num_c;
			w_s2   <= w_c;
			tw_s2  <= {w_c, 1'b0};
		end
	end

	// bin search: one quotient bit per stage
	div1_t div1_first;
	div1_t div1_s [BIN_W];

	always_comb begin
		div1_first.tag    = tag_s2;
		div1_first.num    = num_s2;
		div1_first.w      = w_s2;
		div1_first.tw     = tw_s2;
		div1_first.neg    = num_s2[NUM_W-1];
		div1_first.rem    = div1_first.neg ? '0 : D1_W'(num_s2[NUM_W-2:0]);
		div1_first.sat    = div1_first.rem >= (D1_W'(tw_s2) << BIN_W);
		div1_first.oor_hi = div1_first.rem > (D1_W'(BINS - 1) * D1_W'(tw_s2));
		div1_first.q      = '0;
	end

	for (genvar j = 0; j < BIN_W; j++) begin : g_div1
		localparam int K = BIN_W - 1 - j;
		div1_t cur;
		div1_t nxt;

		if (j == 0) begin : g_first
			assign cur = div1_first;
		end else begin : g_next
			assign cur = div1_s[j-1];
		end

		always_comb begin
			nxt = cur;
			if (cur.rem >= (D1_W'(cur.tw) << K)) begin
				nxt.rem  = cur.rem - (D1_W'(cur.tw) << K);
				nxt.q[K] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div1_s[j] <= '0;
			end else if (adv) begin
				div1_s[j] <= nxt;
			end
		end
	end

	// clamp bin, flag extrapolation
	div1_t                   d1;
	logic [BIN_W-1:0]        bin_c;
	tag_t                    tag_c;
	tag_t                    tag_s3;
	logic signed [NUM_W-1:0] num_s3;
	logic [GEO_W-1:0]        w_s3;
	logic [TW_W-1:0]         tw_s3;
	logic [BIN_W-1:0]        bin_s3;

	always_comb begin
		d1 = div1_s[BIN_W-1];
		if (d1.neg) begin
			bin_c = '0;
		end else if (d1.sat || 32'(d1.q) > BINS - 2) begin
			bin_c = BIN_W'(BINS - 2);
		end else begin
			bin_c = d1.q;
		end
		tag_c = d1.tag;
		if (d1.tag.kind == KIND_LOOKUP) begin
			tag_c.oor = d1.neg || d1.oor_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else if (adv) begin
			tag_s3 <= tag_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s3 <= d1.num;
			w_s3   <= d1.w;
			tw_s3  <= d1.tw;
			bin_s3 <= bin_c;
		end
	end

	// bin offset and sample address
	tag_t                    tag_s4;
	logic signed [NUM_W-1:0] num_s4;
	logic [GEO_W-1:0]        w_s4;
	logic [TW_W-1:0]         tw_s4;
	logic [MB_W-1:0]         binprod_s4;
	logic [SADDR_W-1:0]      addr_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
		end else if (adv) begin
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4     <= num_s3;
			w_s4       <= w_s3;
			tw_s4      <= tw_s3;
			binprod_s4 <= MB_W'(bin_s3) * MB_W'(tw_s3);
			addr_s4    <= SADDR_W'(32'(tag_s3.tix) * BINS
				+ ((tag_s3.kind == KIND_SAMPLE) ? 32'(tag_s3.wbin) : 32'(bin_s3)));
		end
	end

	// sample fetch: two copies give samples bin and bin+1 together
	logic                 swe;
	logic [FIELD_W-1:0]   f1_rd;
	logic [FIELD_W-1:0]   f2_rd;

	assign swe = adv && tag_s4.valid && tag_s4.kind == KIND_SAMPLE;

	bfi_ram #(.WIDTH(FIELD_W), .DEPTH(SAMPLES)) u_lo_ram (
		.clk   (clk),
		.we    (swe),
		.waddr (addr_s4),
		.wdata (tag_s4.val),
		.re    (adv),
		.raddr (addr_s4),
		.rdata (f1_rd)
	);

	bfi_ram #(.WIDTH(FIELD_W), .DEPTH(SAMPLES)) u_hi_ram (
		.clk   (clk),
		.we    (swe),
		.waddr (addr_s4),
		.wdata (tag_s4.val),
		.re    (adv),
		.raddr (addr_s4 + SADDR_W'(1)),
		.rdata (f2_rd)
	);

	tag_t                    tag_s5;
	logic signed [NUM_W-1:0] n2_s5;
	logic [GEO_W-1:0]        w_s5;
	logic [TW_W-1:0]         tw_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5 <= '0;
		end else if (adv) begin
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n2_s5 <= NUM_W'(D1_W'(num_s4) - $signed(D1_W'(binprod_s4)));
			w_s5  <= w_s4;
			tw_s5 <= tw_s4;
		end
	end

	// slope and product
	tag_t                      tag_s6;
	logic signed [DIFF_W-1:0]  diff_s6;
	logic signed [NUM_W-1:0]   n2_s6;
	logic signed [FIELD_W-1:0] f1_s6;
	logic [GEO_W-1:0]          w_s6;
	logic [TW_W-1:0]           tw_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s6 <= '0;
		end else if (adv) begin
			tag_s6 <= tag_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s6 <= DIFF_W'($signed(f2_rd)) - DIFF_W'($signed(f1_rd));
			n2_s6   <= n2_s5;
			f1_s6   <= $signed(f1_rd);
			w_s6    <= w_s5;
			tw_s6   <= tw_s5;
		end
	end

	tag_t                      tag_s7;
	logic signed [PROD_W-1:0]  prod_s7;
	logic signed [FIELD_W-1:0] f1_s7;
	logic [GEO_W-1:0]          w_s7;
	logic [TW_W-1:0]           tw_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s7 <= '0;
		end else if (adv) begin
			tag_s7 <= tag_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s7 <= diff_s6 * n2_s6;
			f1_s7   <= f1_s6;
			w_s7    <= w_s6;
			tw_s7   <= tw_s6;
		end
	end

	tag_t                      tag_s8;
	logic signed [A_W-1:0]     a_s8;
	logic signed [FIELD_W-1:0] f1_s8;
	logic [TW_W-1:0]           tw_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s8 <= '0;
		end else if (adv) begin
			tag_s8 <= tag_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s8  <= A_W'(prod_s7) + $signed(A_W'(w_s7));
			f1_s8 <= f1_s7;
			tw_s8 <= tw_s7;
		end
	end

	// floor division of the rounded product, magnitude form
	div2_t                 div2_first;
	div2_t                 div2_s [Q_W];
	logic signed [A_W-1:0] tws_c;

	always_comb begin
		tws_c          = $signed(A_W'(tw_s8));
		div2_first.tag = tag_s8;
		div2_first.f1  = f1_s8;
		div2_first.tw  = tw_s8;
		div2_first.neg = a_s8[A_W-1];
		div2_first.rem = div2_first.neg ? $unsigned(tws_c - a_s8 - A_W'(1)) : $unsigned(a_s8);
		div2_first.sat = div2_first.rem >= (A_W'(tw_s8) << Q_W);
		div2_first.q   = '0;
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_div2
		localparam int K = Q_W - 1 - j;
		div2_t cur;
		div2_t nxt;

		if (j == 0) begin : g_first
			assign cur = div2_first;
		end else begin : g_next
			assign cur = div2_s[j-1];
		end

		always_comb begin
			nxt = cur;
			if (cur.rem >= (A_W'(cur.tw) << K)) begin
				nxt.rem  = cur.rem - (A_W'(cur.tw) << K);
				nxt.q[K] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div2_s[j] <= '0;
			end else if (adv) begin
				div2_s[j] <= nxt;
			end
		end
	end

	// final sum, saturation and result register
	div2_t                   e;
	logic [Q_W-1:0]          q2;
	logic signed [RES_W-1:0] interp;
	logic signed [RES_W-1:0] res;
	logic signed [RES_W-1:0] res_sat;

	always_comb begin
		e      = div2_s[Q_W-1];
		q2     = e.sat ? {Q_W{1'b1}} : e.q;
		interp = e.neg ? -$signed(RES_W'(q2)) : $signed(RES_W'(q2));
		res    = RES_W'(e.f1) + interp;
		if (res > RES_MAX) begin
			res_sat = RES_MAX;
		end else if (res < RES_MIN) begin
			res_sat = RES_MIN;
		end else begin
			res_sat = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= e.tag.valid
				&& (e.tag.kind == KIND_LOOKUP || e.tag.kind == KIND_CONST);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp.out_of_range <= e.tag.oor;
			rsp.field_value  <= (e.tag.kind == KIND_CONST) ? $signed(e.tag.val)
				: FIELD_W'(res_sat);
		end
	end

endmodule

### sv/binned_field_interpolator.sv
// ----------------------------------------------------------------------------
// binned_field_interpolator
// Per-layer piecewise linear field lookup with table load commands.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while the queue has room and the
// result side keeps taking results. Most of the pipeline depth comes from
// the two pipelined restoring dividers, one quotient bit per stage
// (log2(BINS) for the bin search, 26 for the rounding division). Writes
// take the same path and give no result. Table contents are undefined
// until written.
module binned_field_interpolator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  bfi_pkg::bfi_in_t                     req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output bfi_pkg::bfi_out_t                    rsp,
	input  logic                                 cfg_we,
	input  logic [bfi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [bfi_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import bfi_pkg::*;

	bfi_cfg_t cfg_q;
	bfi_op_t  front_op;
	bfi_op_t  head_op;
	logic     keep;
	logic     full;
	logic     empty;
	logic     pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.uniform_mode  <= 1'b0;
			cfg_q.uniform_field <= UNIFORM_FIELD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UNIFORM_MODE:  cfg_q.uniform_mode  <= cfg_data[0];
				REG_UNIFORM_FIELD: cfg_q.uniform_field <= $signed(cfg_data[FIELD_W-1:0]);
				default: ;
			endcase
		end
	end

	assign req_ready = !full;

	bfi_front u_front (
		.req  (req),
		.cfg  (cfg_q),
		.keep (keep),
		.op   (front_op)
	);

	bfi_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (req_valid && req_ready && keep),
		.din    (front_op),
		.pop    (pop),
		.dout   (head_op),
		.full   (full),
		.empty  (empty)
	);

	bfi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (head_op),
		.head_valid (!empty),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule
